// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the slot cache manager, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk and quiet during reset
`define RCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RCM_ASSERT_IMP(lbl, ante, cons)
`define RCM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rcm_pkg;

  // opcodes
  localparam logic [3:0] OP_REF    = 4'd0;
  localparam logic [3:0] OP_ADDREF = 4'd1;
  localparam logic [3:0] OP_SEARCH = 4'd2;
  localparam logic [3:0] OP_DEREF  = 4'd3;
  localparam logic [3:0] OP_CLOB   = 4'd4;
  localparam logic [3:0] OP_COUNT  = 4'd5;
  localparam logic [3:0] OP_FREE   = 4'd6;
  localparam logic [3:0] OP_CLEAN  = 4'd7;
  localparam logic [3:0] OP_FLUSH  = 4'd8;
  localparam logic [3:0] OP_SYNC   = 4'd9;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTVALID = 2'd3;

  // managed slot count after reset
  localparam logic [6:0] CFG_RESET = 7'd64;

  // kind of result the datapath builds
  typedef logic [2:0] kind_t;
  localparam kind_t K_RANGE = 3'd0;
  localparam kind_t K_EMPTY = 3'd1;
  localparam kind_t K_MISS  = 3'd2;
  localparam kind_t K_HIT   = 3'd3;
  localparam kind_t K_FULL  = 3'd4;
  localparam kind_t K_ALLOC = 3'd5;
  localparam kind_t K_RUN   = 3'd6;
  localparam kind_t K_SLOT  = 3'd7;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  alloc_init;
    logic  alloc_step;
    logic  addr_sidx;
    logic  emit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       in_range;
    logic       match;
    logic       scan_end;
    logic       any_qual;
    logic       qual_here;
    logic       last_run;
    logic       slot_free;
    logic       alloc_end;
    logic       out_free;
  } sts_t;

endpackage

// ===== hw/rtl/refcounted_slot_cache_manager.sv =====
// ----------------------------------------------------------------------------
// refcounted_slot_cache_manager
// Reference-counted slot cache with rotating-hand replacement
// ----------------------------------------------------------------------------
// Requests enter on the in_ channel (valid/stall) with an opcode, an object id
// and a slot index; results leave on the out_ channel (valid/stall). The cfg_
// channel (valid/ready, always ready) writes the managed slot count; the user
// must only use it while the block is idle, which the block does not enforce.
// One request is handled at a time; in_stall is high until its sequence ends.
// From acceptance to result load, per request: a slot out of range or an empty
// clean/flush is answered from dispatch; single-slot ops make one read of the
// id and count memories; lookups scan the id memory up to the hit, or through
// all managed slots for a miss; a miss with allocation then walks the hand,
// one slot per hand step; clean/flush scans the slots, with one transfer per
// qualifying slot.
// After the last result load the next request is accepted in the next cycle.
// A result waits in the output register while out_stall is high; the
// sequencer pauses before the next transfer. Reset (rst_n low, synchronous)
// invalidates all slots, zeroes the hand and counters and sets 64 managed
// slots; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_slot_cache_manager #(
  parameter int SLOTS    = 64,
  parameter int ID_BITS  = 32,
  parameter int REF_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [31:0] in_object_id,
  input  logic [5:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [5:0]  out_result_slot,
  output logic [15:0] out_ref_count,
  output logic        out_writeback,
  output logic [31:0] out_writeback_id,
  output logic        out_last,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_slots_in_use
);

  rcm_pkg::cmd_t cmd;
  rcm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  rcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table and result register
  rcm_dp #(
    .SLOTS    (SLOTS),
    .ID_BITS  (ID_BITS),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_object_id     (in_object_id),
    .in_slot_index    (in_slot_index),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_slots_in_use (cfg_slots_in_use),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_hit          (out_hit),
    .out_result_slot  (out_result_slot),
    .out_ref_count    (out_ref_count),
    .out_writeback    (out_writeback),
    .out_writeback_id (out_writeback_id),
    .out_last         (out_last),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .cmd              (cmd),
    .sts              (sts)
  );

  // checks
  `RCM_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RCM_ASSERT_IMP(a_hit_is_clean, out_valid && out_hit,
                  out_status == rcm_pkg::ST_OK && !out_writeback)
  `RCM_ASSERT_IMP(a_writeback_ok, out_valid && out_writeback,
                  out_status == rcm_pkg::ST_OK)

endmodule

// ===== hw/rtl/rcm_ram.sv =====
// ----------------------------------------------------------------------------
// rcm_ram
// Generic one-write one-read RAM with registered read data
// ----------------------------------------------------------------------------
module rcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcm_ctrl
// Sequencer for lookups, allocation scans, single-slot ops and clean/flush runs
// ----------------------------------------------------------------------------
module rcm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rcm_pkg::sts_t  sts,
  output rcm_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_FEV   = 4'd2;
  localparam logic [3:0] S_ASCAN = 4'd3;
  localparam logic [3:0] S_AEV   = 4'd4;
  localparam logic [3:0] S_SEV   = 4'd5;
  localparam logic [3:0] S_CSCAN = 4'd6;
  localparam logic [3:0] S_CEV   = 4'd7;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op) inside
          rcm_pkg::OP_REF, rcm_pkg::OP_ADDREF, rcm_pkg::OP_SEARCH: begin
            state_nxt = S_FEV;
          end
          rcm_pkg::OP_DEREF, rcm_pkg::OP_CLOB, rcm_pkg::OP_COUNT,
          rcm_pkg::OP_FREE, rcm_pkg::OP_SYNC: begin
            if (sts.in_range) begin
              cmd.addr_sidx = 1'b1;
              state_nxt     = S_SEV;
            end else if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.kind  = rcm_pkg::K_RANGE;
              state_nxt = S_IDLE;
            end
          end
          rcm_pkg::OP_CLEAN, rcm_pkg::OP_FLUSH: begin
            if (sts.any_qual) begin
              state_nxt = S_CSCAN;
            end else if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.kind  = rcm_pkg::K_EMPTY;
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FEV: begin
        if (sts.match) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = rcm_pkg::K_HIT;
            state_nxt = S_IDLE;
          end
        end else if (!sts.scan_end) begin
          cmd.step = 1'b1;
        end else if (sts.op == rcm_pkg::OP_SEARCH) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = rcm_pkg::K_MISS;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.alloc_init = 1'b1;
          state_nxt      = S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (sts.slot_free) begin
          state_nxt = S_AEV;
        end else if (!sts.alloc_end) begin
          cmd.alloc_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = rcm_pkg::K_FULL;
          state_nxt = S_IDLE;
        end
      end
      S_AEV: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = rcm_pkg::K_ALLOC;
          state_nxt = S_IDLE;
        end
      end
      S_SEV: begin
        cmd.addr_sidx = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = rcm_pkg::K_SLOT;
          state_nxt = S_IDLE;
        end
      end
      S_CSCAN: begin
        if (sts.qual_here) begin
          state_nxt = S_CEV;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_CEV: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = rcm_pkg::K_RUN;
          if (sts.last_run) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_CSCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/rcm_dp.sv =====
// ----------------------------------------------------------------------------
// rcm_dp
// Slot table, allocation hand, counters and result register
// ----------------------------------------------------------------------------
module rcm_dp #(
  parameter int SLOTS    = 64,
  parameter int ID_BITS  = 32,
  parameter int REF_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           in_opcode,
  input  logic [31:0]          in_object_id,
  input  logic [5:0]           in_slot_index,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_slots_in_use,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_hit,
  output logic [5:0]           out_result_slot,
  output logic [15:0]          out_ref_count,
  output logic                 out_writeback,
  output logic [31:0]          out_writeback_id,
  output logic                 out_last,
  output logic [31:0]          out_hit_total,
  output logic [31:0]          out_miss_total,
  input  rcm_pkg::cmd_t        cmd,
  output rcm_pkg::sts_t        sts
);

  localparam int IW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [6:0]          cfg_r;
  logic [3:0]          op_r;
  logic [ID_BITS-1:0]  id_r;
  logic [5:0]          sidx_r;
  logic [IW-1:0]       ptr_r, ptr_nxt, start_r, start_sel, eidx, raddr;
  logic [NW-1:0]       cnt_r, hand_r, hand_nxt, n;
  logic [SLOTS-1:0]    valid_r, valid_nxt, nz_r, nz_nxt, clob_r, clob_nxt;
  logic [SLOTS-1:0]    qual, above;
  logic [31:0]         hits_r, hits_nxt, miss_r, miss_nxt;
  logic [ID_BITS-1:0]  id_rd, id_cur;
  logic [REF_BITS-1:0] ref_rd, ref_cur, ref_bump, ref_dec, ref_wdata;
  logic                cur_valid, id_we, ref_we, out_valid_r;

  // result fields before registering
  logic [1:0]          o_status;
  logic                o_hit, o_wb, o_last;
  logic [IW-1:0]       o_slot;
  logic [REF_BITS-1:0] o_refs;
  logic [ID_BITS-1:0]  o_wbid;

  // managed slot count, clamped to 1..SLOTS
  always_comb begin
    if (cfg_r == 7'd0) begin
      n = NW'(1);
    end else if (cfg_r > 7'(SLOTS)) begin
      n = NW'(SLOTS);
    end else begin
      n = NW'(cfg_r);
    end
  end

  assign start_sel = (hand_r >= n) ? '0 : hand_r[IW-1:0];

  // scan pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = '0;
    end else if (cmd.alloc_init) begin
      ptr_nxt = start_sel;
    end else if (cmd.alloc_step) begin
      ptr_nxt = (NW'(ptr_r) + NW'(1) >= n) ? '0 : ptr_r + IW'(1);
    end else if (cmd.step) begin
      ptr_nxt = ptr_r + IW'(1);
    end
  end

  assign raddr = cmd.addr_sidx ? sidx_r[IW-1:0] : ptr_nxt;
  assign eidx  = (cmd.kind == rcm_pkg::K_SLOT) ? sidx_r[IW-1:0] : ptr_r;

  // id and count stores
  rcm_ram #(.WIDTH(ID_BITS), .DEPTH(SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (eidx),
    .wdata (id_r),
    .raddr (raddr),
    .rdata (id_rd)
  );

  rcm_ram #(.WIDTH(REF_BITS), .DEPTH(SLOTS)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (eidx),
    .wdata (ref_wdata),
    .raddr (raddr),
    .rdata (ref_rd)
  );

  // an invalid slot always reads as id 0, count 0
  assign cur_valid = valid_r[eidx];
  assign id_cur    = cur_valid ? id_rd : '0;
  assign ref_cur   = cur_valid ? ref_rd : '0;
  assign ref_bump  = (ref_cur == REF_MAX) ? REF_MAX : ref_cur + REF_BITS'(1);
  assign ref_dec   = (ref_cur != '0) ? ref_cur - REF_BITS'(1) : '0;

  // clean/flush candidates
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      qual[i]  = valid_r[i] && (op_r == rcm_pkg::OP_FLUSH || !nz_r[i]) && (NW'(i) < n);
      above[i] = qual[i] && (IW'(i) > ptr_r);
    end
  end

  // status to the sequencer
  always_comb begin
    sts.op        = op_r;
    sts.in_range  = (sidx_r < 6'(n - NW'(1))) || (sidx_r == 6'(n - NW'(1)));
    sts.match     = valid_r[ptr_r] && (id_rd == id_r);
    sts.scan_end  = (NW'(ptr_r) + NW'(1) >= n);
    sts.any_qual  = |qual;
    sts.qual_here = qual[ptr_r];
    sts.last_run  = ~|above;
    sts.slot_free = !nz_r[ptr_r];
    sts.alloc_end = (cnt_r + NW'(1) >= n);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // result build and table update
  always_comb begin
    o_status  = rcm_pkg::ST_OK;
    o_hit     = 1'b0;
    o_slot    = '0;
    o_refs    = '0;
    o_wb      = 1'b0;
    o_wbid    = '0;
    o_last    = 1'b1;
    valid_nxt = valid_r;
    nz_nxt    = nz_r;
    clob_nxt  = clob_r;
    hand_nxt  = hand_r;
    hits_nxt  = hits_r;
    miss_nxt  = miss_r;
    id_we     = 1'b0;
    ref_we    = 1'b0;
    ref_wdata = '0;
    if (cmd.emit) begin
      case (cmd.kind)
        rcm_pkg::K_RANGE: o_status = rcm_pkg::ST_RANGE;
        rcm_pkg::K_HIT: begin
          o_hit        = 1'b1;
          o_slot       = ptr_r;
          o_refs       = ref_bump;
          ref_we       = 1'b1;
          ref_wdata    = ref_bump;
          nz_nxt[eidx] = 1'b1;
          if (op_r == rcm_pkg::OP_REF) hits_nxt = hits_r + 32'd1;
        end
        rcm_pkg::K_FULL: begin
          o_status = rcm_pkg::ST_FULL;
          hand_nxt = NW'(start_r) + NW'(1);
          if (op_r == rcm_pkg::OP_REF) miss_nxt = miss_r + 32'd1;
        end
        rcm_pkg::K_ALLOC: begin
          o_slot          = ptr_r;
          o_refs          = REF_BITS'(1);
          o_wb            = cur_valid;
          o_wbid          = id_cur;
          id_we           = 1'b1;
          ref_we          = 1'b1;
          ref_wdata       = REF_BITS'(1);
          valid_nxt[eidx] = 1'b1;
          nz_nxt[eidx]    = 1'b1;
          clob_nxt[eidx]  = 1'b0;
          hand_nxt        = NW'(ptr_r) + NW'(1);
          if (op_r == rcm_pkg::OP_REF) miss_nxt = miss_r + 32'd1;
        end
        rcm_pkg::K_RUN: begin
          o_slot = ptr_r;
          o_refs = ref_cur;
          o_wb   = 1'b1;
          o_wbid = id_cur;
          o_last = ~|above;
          if (op_r == rcm_pkg::OP_CLEAN) valid_nxt[eidx] = 1'b0;
        end
        rcm_pkg::K_SLOT: begin
          o_slot = eidx;
          if (!cur_valid && (op_r == rcm_pkg::OP_DEREF || op_r == rcm_pkg::OP_CLOB ||
                             op_r == rcm_pkg::OP_COUNT)) begin
            o_status = rcm_pkg::ST_NOTVALID;
          end else begin
            case (op_r)
              rcm_pkg::OP_DEREF: begin
                ref_we       = 1'b1;
                ref_wdata    = ref_dec;
                nz_nxt[eidx] = (ref_dec != '0);
                o_refs       = ref_dec;
                if (ref_dec == '0 && clob_r[eidx]) begin
                  o_wb            = 1'b1;
                  o_wbid          = id_cur;
                  valid_nxt[eidx] = 1'b0;
                end
              end
              rcm_pkg::OP_CLOB: begin
                clob_nxt[eidx] = 1'b1;
                o_refs         = ref_cur;
              end
              rcm_pkg::OP_COUNT: o_refs = ref_cur;
              rcm_pkg::OP_FREE: begin
                valid_nxt[eidx] = 1'b0;
                nz_nxt[eidx]    = 1'b0;
              end
              rcm_pkg::OP_SYNC: begin
                o_wb   = 1'b1;
                o_wbid = id_cur;
                o_refs = ref_cur;
              end
              default: o_refs = '0;
            endcase
          end
        end
        default: o_last = 1'b1;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= rcm_pkg::CFG_RESET;
      valid_r     <= '0;
      nz_r        <= '0;
      clob_r      <= '0;
      hand_r      <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_slots_in_use;
      valid_r <= valid_nxt;
      nz_r    <= nz_nxt;
      clob_r  <= clob_nxt;
      hand_r  <= hand_nxt;
      hits_r  <= hits_nxt;
      miss_r  <= miss_nxt;
      ptr_r   <= ptr_nxt;
      if (cmd.alloc_init) begin
        cnt_r <= '0;
      end else if (cmd.alloc_step) begin
        cnt_r <= cnt_r + NW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operands and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      id_r   <= ID_BITS'(in_object_id);
      sidx_r <= in_slot_index;
    end
    if (cmd.alloc_init) start_r <= start_sel;
    if (cmd.emit) begin
      out_status       <= o_status;
      out_hit          <= o_hit;
      out_result_slot  <= 6'(o_slot);
      out_ref_count    <= 16'(o_refs);
      out_writeback    <= o_wb;
      out_writeback_id <= 32'(o_wbid);
      out_last         <= o_last;
      out_hit_total    <= hits_nxt;
      out_miss_total   <= miss_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
